>>> hdl/sobel_pkg.sv
// Shared types, widths and register codes of the Sobel edge threshold stream.
package sobel_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned ADDR_W   = $clog2(MAX_WIDTH);

  localparam int unsigned Q_DEPTH  = 8;
  localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned CREDIT_W = $clog2(Q_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 13'd480;
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 10'd50;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  typedef struct packed {
    logic [WIDTH_W-1:0]  image_width;
    logic [HEIGHT_W-1:0] image_height;
    logic [THR_W-1:0]    edge_threshold;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             has_edge;
    logic             edge_white;
    logic             is_border;
  } item_t;

endpackage

>>> hdl/sobel_cfg.sv
// APB-style configuration registers of the Sobel edge threshold stream.
module sobel_cfg import sobel_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= WIDTH_RESET;
      cfg_q.image_height   <= HEIGHT_RESET;
      cfg_q.edge_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:    cfg_q.image_width    <= pwdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_q.image_height   <= pwdata[HEIGHT_W-1:0];
        REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(cfg_q.image_width);
      REG_IMAGE_HEIGHT:   prdata = APB_DATA_W'(cfg_q.image_height);
      REG_EDGE_THRESHOLD: prdata = APB_DATA_W'(cfg_q.edge_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> hdl/sobel_front.sv
// Front end: position counters, line stores, window and gradient pipeline.
module sobel_front import sobel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             push_i,
  output logic             full_o,
  input  logic [PIX_W-1:0] red_i,
  input  logic [PIX_W-1:0] green_i,
  input  logic [PIX_W-1:0] blue_i,
  input  logic             first_of_frame_i,
  input  logic             retire_i,
  output logic             q_wr_o,
  output item_t            q_item_o
);

  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic                accept;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ROW_W-1:0]    r0, r_s;
  logic [COL_W-1:0]    c0, c_s;
  logic [HEIGHT_W-1:0] r_inc, r_nxt;
  logic [WIDTH_W-1:0]  c_nxt;
  logic                s0_border, s0_edge;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_upper_q, rd_lower_q;
  logic             byp_q;
  logic [PIX_W-1:0] byp_data_q;

  logic             s1_valid_q, s2_valid_q, s3_valid_q;
  item_t            s1_item_q, s2_item_q, s3_item_q;
  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] top;

  logic signed [10:0] nw, wv, sw, nn, ss, ne, ev, se;
  logic signed [10:0] gx, gy, gx_q, gy_q;
  logic signed [21:0] sqx, sqy;
  logic [20:0]        sqx_q, sqy_q;
  logic [11:0]        lim;
  logic [23:0]        lim_sq_q;
  logic [21:0]        mag;
  logic               s3_white, s3_none;

  assign accept = push_i && !full_o;
  assign full_o = (credit_q == CREDIT_W'(Q_DEPTH));

  always_comb begin
    w_eff = cfg_i.image_width;
    if (w_eff == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (w_eff > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end
    h_eff = cfg_i.image_height;
    if (h_eff == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (h_eff > HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end
  end

  always_comb begin
    r0 = first_of_frame_i ? '0 : row_q;
    c0 = first_of_frame_i ? '0 : col_q;
    r_inc = {1'b0, r0};
    c_s = c0;
    if ({1'b0, c0} >= w_eff) begin
      c_s = '0;
      r_inc = {1'b0, r0} + HEIGHT_W'(1);
    end
    if (r_inc >= h_eff) begin
      r_inc = '0;
    end
    r_s = r_inc[ROW_W-1:0];

    c_nxt = {1'b0, c_s} + WIDTH_W'(1);
    r_nxt = {1'b0, r_s};
    if (c_nxt >= w_eff) begin
      c_nxt = '0;
      r_nxt = r_nxt + HEIGHT_W'(1);
      if (r_nxt >= h_eff) begin
        r_nxt = '0;
      end
    end
    row_d = r_nxt[ROW_W-1:0];
    col_d = c_nxt[COL_W-1:0];

    s0_border = (r_s == '0) || ({1'b0, r_s} == h_eff - HEIGHT_W'(1)) ||
                (c_s == '0) || ({1'b0, c_s} == w_eff - WIDTH_W'(1));
    s0_edge   = (r_s >= ROW_W'(2)) && (c_s >= COL_W'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_lower_q <= lower_mem[c_s[ADDR_W-1:0]];
      lower_mem[c_s[ADDR_W-1:0]] <= blue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_upper_q <= upper_mem[c_s[ADDR_W-1:0]];
    end
    if (s1_valid_q) begin
      upper_mem[s1_item_q.col[ADDR_W-1:0]] <= rd_lower_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= s1_valid_q && accept && (c_s == s1_item_q.col);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= rd_lower_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.row        <= r_s;
      s1_item_q.col        <= c_s;
      s1_item_q.red        <= red_i;
      s1_item_q.green      <= green_i;
      s1_item_q.blue       <= blue_i;
      s1_item_q.has_edge   <= s0_edge;
      s1_item_q.edge_white <= 1'b0;
      s1_item_q.is_border  <= s0_border;
    end
    s2_item_q <= s1_item_q;
    s3_item_q <= s2_item_q;
  end

  assign top = byp_q ? byp_data_q : rd_upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= rd_lower_q;
      win_q[5] <= s1_item_q.blue;
    end
  end

  always_comb begin
    nw = $signed({3'b000, win_q[0]});
    wv = $signed({3'b000, win_q[1]});
    sw = $signed({3'b000, win_q[2]});
    nn = $signed({3'b000, win_q[3]});
    ss = $signed({3'b000, win_q[5]});
    ne = $signed({3'b000, top});
    ev = $signed({3'b000, rd_lower_q});
    se = $signed({3'b000, s1_item_q.blue});
    gx = (ne - nw) + ((ev - wv) <<< 1) + (se - sw);
    gy = (sw - nw) + ((ss - nn) <<< 1) + (se - ne);
  end

  always_ff @(posedge clk_i) begin
    gx_q <= gx;
    gy_q <= gy;
  end

  assign sqx = gx_q * gx_q;
  assign sqy = gy_q * gy_q;
  assign lim = {cfg_i.edge_threshold, 2'b00};

  always_ff @(posedge clk_i) begin
    sqx_q    <= sqx[20:0];
    sqy_q    <= sqy[20:0];
    lim_sq_q <= lim * lim;
  end

  assign mag      = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign s3_white = {2'b00, mag} > lim_sq_q;
  assign s3_none  = s3_valid_q && !s3_item_q.has_edge && !s3_item_q.is_border;

  always_comb begin
    q_item_o            = s3_item_q;
    q_item_o.edge_white = s3_white;
  end
  assign q_wr_o = s3_valid_q && (s3_item_q.has_edge || s3_item_q.is_border);

  always_comb begin
    credit_d = credit_q + CREDIT_W'(accept) - CREDIT_W'(s3_none) - CREDIT_W'(retire_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

endmodule

>>> hdl/sobel_queue.sv
// Item queue between the front end and the result sequencer.
module sobel_queue import sobel_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wr_item_i,
  input  logic  rd_i,
  output item_t head_o,
  output logic  empty_o
);

  item_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wptr_q, rptr_q;
  logic [CREDIT_W-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + Q_PTR_W'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + Q_PTR_W'(1);
      end
      count_q <= count_q + CREDIT_W'(wr_i) - CREDIT_W'(rd_i);
    end
  end

endmodule

>>> hdl/sobel_back.sv
// Result sequencer: turns each queued item into its edge and border results.
module sobel_back import sobel_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  item_t            head_i,
  input  logic             q_empty_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             retire_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [COL_W-1:0] out_col_o,
  output logic [PIX_W-1:0] out_red_o,
  output logic [PIX_W-1:0] out_green_o,
  output logic [PIX_W-1:0] out_blue_o,
  output logic             last_of_run_o
);

  logic             phase_q;
  logic             edge_phase;
  logic             take;
  logic [PIX_W-1:0] level;

  assign empty_o    = q_empty_i;
  assign take       = pop_i && !q_empty_i;
  assign edge_phase = head_i.has_edge && !phase_q;
  assign level      = head_i.edge_white ? PIX_WHITE : PIX_BLACK;

  always_comb begin
    if (edge_phase) begin
      out_row_o     = head_i.row - ROW_W'(1);
      out_col_o     = head_i.col - COL_W'(1);
      out_red_o     = level;
      out_green_o   = level;
      out_blue_o    = level;
      last_of_run_o = !head_i.is_border;
    end else begin
      out_row_o     = head_i.row;
      out_col_o     = head_i.col;
      out_red_o     = head_i.red;
      out_green_o   = head_i.green;
      out_blue_o    = head_i.blue;
      last_of_run_o = 1'b1;
    end
  end

  assign retire_o = take && last_of_run_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (take) begin
      phase_q <= !last_of_run_o;
    end
  end

endmodule

>>> hdl/sobel_edge_threshold_stream_top.sv
// Top level of the Sobel edge threshold stream.
// RGB pixels enter in raster order through a queue-like port: a transaction
// takes place at a rising edge with push high and full low. Results leave
// through a second queue-like port: the oldest result shows while empty is
// low and is taken at an edge with pop high. A border pixel comes back
// unchanged with its row and column; when a pixel completes the 3x3 window
// of an interior pixel, that pixel comes back white or black from its Sobel
// gradient on the blue channel, ahead of any border result of the same input.
// last_of_run marks the final result caused by one input pixel.
// A pixel's first result passes registers s1, s2 and s3, then the queue.
// One pixel is taken every cycle while full is low; the result side moves one
// result per cycle while pop is high; a two-result pixel takes two pops.
// Image width, height and threshold sit in an APB-style register file and
// are to be written only while the stream is idle, which the block does
// not enforce. Reset clears the position counters, the window and the queue
// and loads the register defaults; the line stores are not cleared. When the
// receiver stalls, an eight-item queue absorbs the results in flight, and
// full rises once eight pixels are held in the pipeline and the queue.
module sobel_edge_threshold_stream_top import sobel_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic [PIX_W-1:0]      red_i,
  input  logic [PIX_W-1:0]      green_i,
  input  logic [PIX_W-1:0]      blue_i,
  input  logic                  first_of_frame_i,
  input  logic                  push,
  output logic                  full,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic [PIX_W-1:0]      out_red_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic                  last_of_run_o,
  output logic                  empty,
  input  logic                  pop
);

  cfg_t  cfg;
  logic  q_wr;
  item_t q_wr_item;
  item_t q_head;
  logic  q_empty;
  logic  retire;

  sobel_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sobel_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .push_i           (push),
    .full_o           (full),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .first_of_frame_i (first_of_frame_i),
    .retire_i         (retire),
    .q_wr_o           (q_wr),
    .q_item_o         (q_wr_item)
  );

  sobel_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .rd_i      (retire),
    .head_o    (q_head),
    .empty_o   (q_empty)
  );

  sobel_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_empty_i     (q_empty),
    .pop_i         (pop),
    .empty_o       (empty),
    .retire_o      (retire),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> hdl/sobel_checker.sv
// Port-level checker of the Sobel edge threshold stream and its bind.
module sobel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [11:0] out_row_o,
  input logic [9:0]  out_col_o,
  input logic [7:0]  out_red_o,
  input logic [7:0]  out_green_o,
  input logic [7:0]  out_blue_o,
  input logic        last_of_run_o
);

  // A stalled result stays on the ports unchanged.
  property p_stall_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && !pop) |=> (!empty && $stable(out_row_o) && $stable(out_col_o) &&
                            $stable(out_red_o) && $stable(out_green_o) &&
                            $stable(out_blue_o) && $stable(last_of_run_o));
  endproperty
  a_stall_hold: assert property (p_stall_hold) else $error("stalled result changed");

  // A result that is not the last of its input is an edge decision: black or white.
  property p_edge_level;
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && !last_of_run_o) |->
        (out_red_o == out_green_o && out_green_o == out_blue_o &&
         (out_red_o == 8'h00 || out_red_o == 8'hFF));
  endproperty
  a_edge_level: assert property (p_edge_level) else $error("edge result is not black or white");

  // An edge result lies off the first row and column.
  property p_edge_inside;
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && !last_of_run_o) |-> (out_row_o != 12'd0 && out_col_o != 10'd0);
  endproperty
  a_edge_inside: assert property (p_edge_inside) else $error("edge result on first row or column");

  // After an edge transaction, the border result of the same input follows at once,
  // one row and one column further on.
  property p_pair;
    @(posedge clk_i) disable iff (!rst_ni)
      (!empty && pop && !last_of_run_o) |=>
        (!empty && last_of_run_o &&
         out_row_o == $past(out_row_o) + 12'd1 &&
         out_col_o == $past(out_col_o) + 10'd1);
  endproperty
  a_pair: assert property (p_pair) else $error("border result does not follow its edge result");

endmodule

bind sobel_edge_threshold_stream_top sobel_checker u_sobel_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_row_o     (out_row_o),
  .out_col_o     (out_col_o),
  .out_red_o     (out_red_o),
  .out_green_o   (out_green_o),
  .out_blue_o    (out_blue_o),
  .last_of_run_o (last_of_run_o)
);

>>> test/testbench.sv
// Self-checking testbench for the Sobel edge threshold stream, with a predictor and random traffic.
module testbench;
  import sobel_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE        = 12;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned IDLE_PCT      = 22;
  localparam int unsigned RANDOM_PIXELS = 440;
  localparam int unsigned PHASE_CAP     = 150;
  localparam int unsigned WIDE_PIXELS   = 64;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } out_pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic [PIX_W-1:0]      red_i;
  logic [PIX_W-1:0]      green_i;
  logic [PIX_W-1:0]      blue_i;
  logic                  first_of_frame_i;
  logic                  push;
  logic                  full;
  logic [ROW_W-1:0]      out_row_o;
  logic [COL_W-1:0]      out_col_o;
  logic [PIX_W-1:0]      out_red_o;
  logic [PIX_W-1:0]      out_green_o;
  logic [PIX_W-1:0]      out_blue_o;
  logic                  last_of_run_o;
  logic                  empty;
  logic                  pop;

  sobel_edge_threshold_stream_top dut (.*);

  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  logic [THR_W-1:0]    cfg_thr;
  logic [PIX_W-1:0]    line_upper [MAX_WIDTH];
  logic [PIX_W-1:0]    line_lower [MAX_WIDTH];
  bit                  known_upper [MAX_WIDTH];
  bit                  known_lower [MAX_WIDTH];
  logic [PIX_W-1:0]    win [6];
  bit [5:0]            known_win;
  int                  row_pos;
  int                  col_pos;

  out_pixel_t  pending_out_pixels [$];
  int unsigned mismatches;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned white_edges;
  int unsigned black_edges;
  int unsigned border_pixels;
  int unsigned full_stalls;
  int unsigned settings_used;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  always #10 clk_i = ~clk_i;

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function automatic int eff_width();
    int w;
    w = cfg_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_height;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic void frame_pos(input bit fof, output int r, output int c);
    r = fof ? 0 : row_pos;
    c = fof ? 0 : col_pos;
    if (c >= eff_width()) begin
      c = 0;
      r++;
    end
    if (r >= eff_height()) r = 0;
  endfunction

  // A gradient must never be built from a line store entry that was never written.
  function automatic bit reads_unwritten();
    int r, c;
    frame_pos(1'b0, r, c);
    return r >= 2 && c >= 2 && !(known_upper[c] && known_lower[c] && known_win[0] &&
           known_win[1] && known_win[2] && known_win[3] && known_win[5]);
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] red, green, blue, input bit fof);
    int r, c, w, h, gx, gy;
    int nw, wv, sw, nn, ss, ne, ev, se;
    int unsigned mag, lim;
    logic [PIX_W-1:0] top, mid, v;
    bit is_border;
    out_pixel_t px;
    w = eff_width();
    h = eff_height();
    frame_pos(fof, r, c);
    top = line_upper[c];
    mid = line_lower[c];
    is_border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
    if (r >= 2 && c >= 2) begin
      nw = win[0]; wv = win[1]; sw = win[2];
      nn = win[3]; ss = win[5];
      ne = top; ev = mid; se = blue;
      gx = -nw + ne - 2 * wv + 2 * ev - sw + se;
      gy = sw + 2 * ss + se - nw - 2 * nn - ne;
      mag = gx * gx + gy * gy;
      lim = 4 * cfg_thr;
      v = (mag > lim * lim) ? PIX_WHITE : PIX_BLACK;
      if (v == PIX_WHITE) white_edges++;
      else black_edges++;
      px.row = ROW_W'(r - 1);
      px.col = COL_W'(c - 1);
      px.red = v;
      px.green = v;
      px.blue = v;
      px.last = !is_border;
      pending_out_pixels.push_back(px);
    end
    if (is_border) begin
      border_pixels++;
      px.row = ROW_W'(r);
      px.col = COL_W'(c);
      px.red = red;
      px.green = green;
      px.blue = blue;
      px.last = 1'b1;
      pending_out_pixels.push_back(px);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = blue;
    known_win = {1'b1, known_lower[c], known_upper[c], known_win[5:3]};
    line_upper[c] = mid;
    known_upper[c] = known_lower[c];
    line_lower[c] = blue;
    known_lower[c] = 1'b1;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] red, green, blue, input bit fof);
    if (!quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    if (!fof && reads_unwritten()) fof = 1'b1;
    red_i <= red;
    green_i <= green;
    blue_i <= blue;
    first_of_frame_i <= fof;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    predict_pixel(red, green, blue, fof);
    pixels_sent++;
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    while (pending_out_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    int unsigned want;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    want = 0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        cfg_width = value[WIDTH_W-1:0];
        want = cfg_width;
      end
      REG_IMAGE_HEIGHT: begin
        cfg_height = value[HEIGHT_W-1:0];
        want = cfg_height;
      end
      REG_EDGE_THRESHOLD: begin
        cfg_thr = value[THR_W-1:0];
        want = cfg_thr;
      end
      default: ;
    endcase
    apb_read(idx, data);
    check_field($sformatf("register %0d readback", idx), want, data);
  endtask

  task automatic configure(input logic [WIDTH_W-1:0] w, input logic [HEIGHT_W-1:0] h,
                           input logic [THR_W-1:0] t);
    apb_write(REG_IMAGE_WIDTH, w);
    apb_write(REG_IMAGE_HEIGHT, h);
    apb_write(REG_EDGE_THRESHOLD, t);
    settings_used++;
  endtask

  task automatic test_register_defaults();
    logic [APB_DATA_W-1:0] data;
    apb_read(REG_IMAGE_WIDTH, data);
    check_field("image_width after reset", WIDTH_RESET, data);
    apb_read(REG_IMAGE_HEIGHT, data);
    check_field("image_height after reset", HEIGHT_RESET, data);
    apb_read(REG_EDGE_THRESHOLD, data);
    check_field("edge_threshold after reset", THRESHOLD_RESET, data);
    send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    send_pixel(8'hAB, 8'hCD, 8'hEF, 1'b0);
    wait_for_results();
  endtask

  task automatic test_tiny_frames();
    configure('0, '0, THRESHOLD_RESET);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    wait_for_results();
  endtask

  task automatic test_gradient_extremes();
    configure(11'd3, 13'd3, '0);
    for (int i = 0; i < 9; i++) begin
      send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00,
                 (i % 3 == 2) ? 8'hFF : 8'h00, i == 0);
    end
    wait_for_results();
    configure(11'd3, 13'd3, 10'h3FF);
    for (int i = 0; i < 9; i++) begin
      send_pixel(i[1] ? 8'h00 : 8'hFF, i[0] ? 8'h00 : 8'hFF,
                 (i < 3) ? 8'hFF : 8'h00, i == 0);
    end
    wait_for_results();
  endtask

  task automatic test_mid_frame_change();
    configure(11'd3, 13'd6, 10'd20);
    for (int i = 0; i < 6; i++) begin
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), i == 0);
    end
    wait_for_results();
    apb_write(REG_IMAGE_HEIGHT, 13'd2);
    for (int i = 0; i < 2; i++) begin
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0);
    end
    wait_for_results();
    apb_write(REG_IMAGE_WIDTH, 11'd2);
    send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    configure(11'd6, 13'd5, 10'd40);
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) begin
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), i == 0);
    end
    quiet = 1'b0;
    wait_for_results();
  endtask

  task automatic test_max_width();
    configure(11'h7FF, MAX_HEIGHT, 10'd30);
    for (int i = 0; i < WIDE_PIXELS; i++) begin
      send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), i == 0);
    end
    wait_for_results();
  endtask

  task automatic test_random_frames();
    int sent, phase, per_frame, total, mode;
    logic [WIDTH_W-1:0] wreg;
    logic [HEIGHT_W-1:0] hreg;
    logic [THR_W-1:0] treg;
    logic [PIX_W-1:0] base, b;
    bit fof;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_PIXELS) begin
      quiet = (phase >= 2 && phase <= 4);
      case ($urandom_range(0, 19))
        0: wreg = '0;
        1, 2: wreg = WIDTH_W'($urandom_range(1, 2));
        3, 4: wreg = WIDTH_W'($urandom_range(10, 40));
        default: wreg = WIDTH_W'($urandom_range(3, 9));
      endcase
      case ($urandom_range(0, 19))
        0: hreg = '0;
        1: hreg = HEIGHT_W'($urandom_range(1, 2));
        2: hreg = HEIGHT_W'(MAX_HEIGHT);
        3: hreg = 13'h1FFF;
        4, 5: hreg = HEIGHT_W'($urandom_range(8, 20));
        default: hreg = HEIGHT_W'($urandom_range(3, 7));
      endcase
      case ($urandom_range(0, 9))
        0: treg = '0;
        1: treg = 10'h3FF;
        2, 3: treg = THR_W'($urandom_range(0, 1023));
        default: treg = THR_W'($urandom_range(0, 100));
      endcase
      configure(wreg, hreg, treg);
      per_frame = eff_width() * eff_height();
      total = per_frame * $urandom_range(1, 3);
      if (total > PHASE_CAP) total = PHASE_CAP;
      if ($urandom_range(0, 9) == 0) total = $urandom_range(1, total);
      mode = $urandom_range(0, 2);
      base = PIX_W'($urandom_range(0, 248));
      for (int i = 0; i < total; i++) begin
        case (mode)
          0: b = PIX_W'($urandom_range(0, 255));
          1: b = PIX_W'(base + $urandom_range(0, 7));
          default: b = ($urandom_range(0, 3) == 0) ? PIX_WHITE : PIX_BLACK;
        endcase
        if (i % per_frame == 0) fof = ($urandom_range(0, 9) != 0);
        else fof = ($urandom_range(0, 39) == 0);
        send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)), b, fof);
      end
      wait_for_results();
      sent += total;
      phase++;
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_pixel_t want;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (pending_out_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual row %0d col %0d",
                 $time, out_row_o, out_col_o);
      end else begin
        want = pending_out_pixels.pop_front();
        check_field("out_row", want.row, out_row_o);
        check_field("out_col", want.col, out_col_o);
        check_field("out_red", want.red, out_red_o);
        check_field("out_green", want.green, out_green_o);
        check_field("out_blue", want.blue, out_blue_o);
        check_field("last_of_run", want.last, last_of_run_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_out_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    first_of_frame_i = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    cfg_thr = THRESHOLD_RESET;
    for (int i = 0; i < 6; i++) win[i] = '0;
    known_win = '1;
    row_pos = 0;
    col_pos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_tiny_frames();
    test_gradient_extremes();
    test_mid_frame_change();
    test_backpressure();
    test_max_width();
    test_random_frames();
    wait_for_results();
    $display("Sent %0d pixels over %0d register settings; checked %0d results",
             pixels_sent, settings_used, results_seen);
    $display("(%0d white, %0d black, %0d border); input held off for %0d cycles.",
             white_edges, black_edges, border_pixels, full_stalls);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
